// ===== rtl/linear_probe_hash_set_macros.svh =====
// Assertion macros shared by the hash set RTL.
// They expect clk and rst_n in the enclosing module.
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH
`ifndef SYNTHESIS
`define LPHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPHS_ASSERT_IMP(lbl, ante, cons, msg)
`define LPHS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lphs_pkg.sv =====
package lphs_pkg;

  localparam int FUNC_W  = 2;
  localparam int MARK_W  = 2;
  localparam int OCC_W   = 8;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_FIND   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_NONE   = 2'd3;

  localparam logic [MARK_W-1:0] MARK_NEVER = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic              load;
    logic              mod_step;
    logic              set_home;
    logic              rd_en;
    logic              wr_en;
    logic [MARK_W-1:0] wr_mark;
    logic              ptr_adv;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_load;
    logic              res_hit;
    logic              res_full;
  } lphs_cmd_t;

  typedef struct packed {
    logic              mod_last;
    logic              ptr_last;
    logic              at_home;
    logic              next_home;
    logic [MARK_W-1:0] mark;
    logic              key_eq;
  } lphs_sts_t;

endpackage

// ===== rtl/lphs_ram.sv =====
module lphs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 251
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lphs_dp.sv =====
`include "linear_probe_hash_set_macros.svh"

module lphs_dp #(
  parameter int BUCKETS  = 251,
  parameter int KEY_BITS = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [KEY_BITS-1:0]        in_key,
  input  lphs_pkg::lphs_cmd_t        cmd,
  output lphs_pkg::lphs_sts_t        sts,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic                       out_full_res,
  output logic [lphs_pkg::OCC_W-1:0] out_occupancy
);

  localparam int IDX_W       = $clog2(BUCKETS);
  localparam int CNT_W       = $clog2(BUCKETS + 1);
  localparam int MOD_STEPS   = 2;
  localparam int MSTEP_W     = $clog2(MOD_STEPS);
  localparam int RAM_W       = KEY_BITS + lphs_pkg::MARK_W;
  localparam int RECIP_SHIFT = KEY_BITS + IDX_W;
  localparam int PROD_W      = 2 * KEY_BITS + 1;

  // ceil(2^RECIP_SHIFT / BUCKETS) gives the exact quotient for every key
  localparam logic [RECIP_SHIFT:0] SHIFT_ONE  = {1'b1, {RECIP_SHIFT{1'b0}}};
  localparam logic [RECIP_SHIFT:0] RECIP_FULL =
    (SHIFT_ONE + (RECIP_SHIFT + 1)'(BUCKETS - 1)) / (RECIP_SHIFT + 1)'(BUCKETS);
  localparam logic [KEY_BITS:0]    RECIP      = RECIP_FULL[KEY_BITS:0];

  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(BUCKETS - 1);
  localparam logic [IDX_W-1:0]   BKT_LO     = IDX_W'(BUCKETS);
  localparam logic [MSTEP_W-1:0] MSTEP_LAST = MSTEP_W'(MOD_STEPS - 1);

  logic [KEY_BITS-1:0] key_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MSTEP_W-1:0]  mstep_r;
  logic [IDX_W-1:0]    ptr_r;
  logic [IDX_W-1:0]    home_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                hit_r;
  logic                full_r;
  logic [lphs_pkg::OCC_W-1:0] occ_r;

  logic [IDX_W-1:0]    quot_lo;
  logic [IDX_W-1:0]    rem_step;
  logic [IDX_W-1:0]    ptr_inc;
  logic [RAM_W-1:0]    rd_data;
  logic [RAM_W-1:0]    wr_data;

  // Remainder fits in IDX_W bits, so only the low bits of key - q*BUCKETS matter.
  assign quot_lo  = IDX_W'(prod_r >> RECIP_SHIFT);
  assign rem_step = IDX_W'(key_r) - quot_lo * BKT_LO;

  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + IDX_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      count_r     <= '0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.res_load;
      if (cmd.load) begin
        mstep_r <= '0;
      end else if (cmd.mod_step) begin
        mstep_r <= mstep_r + MSTEP_W'(1);
      end
      if (cmd.set_home) begin
        ptr_r <= rem_step;
      end else if (cmd.ptr_adv) begin
        ptr_r <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    if (cmd.mod_step) begin
      prod_r <= PROD_W'(key_r) * PROD_W'(RECIP);
    end
    if (cmd.set_home) begin
      home_r <= rem_step;
    end
    if (cmd.res_load) begin
      hit_r  <= cmd.res_hit;
      full_r <= cmd.res_full;
      occ_r  <= lphs_pkg::OCC_W'(count_nxt);
    end
  end

  assign wr_data = {cmd.wr_mark, key_r};

  lphs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .re    (cmd.rd_en),
    .addr  (ptr_r),
    .wdata (wr_data),
    .rdata (rd_data)
  );

  assign sts.mod_last  = (mstep_r == MSTEP_LAST);
  assign sts.ptr_last  = (ptr_r == LAST_IDX);
  assign sts.at_home   = (ptr_r == home_r);
  assign sts.next_home = (ptr_inc == home_r);
  assign sts.mark      = rd_data[RAM_W-1 -: lphs_pkg::MARK_W];
  assign sts.key_eq    = (rd_data[KEY_BITS-1:0] == key_r);

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_full_res  = full_r;
  assign out_occupancy = occ_r;

  `LPHS_ASSERT_IMP(a_cnt_no_overflow, cmd.cnt_inc, count_r < CNT_W'(BUCKETS),
                   "insert past capacity")
  `LPHS_ASSERT_IMP(a_cnt_no_underflow, cmd.cnt_dec, count_r != '0,
                   "erase with no bucket in use")
  `LPHS_ASSERT_IMP(a_write_in_use_only, cmd.cnt_dec, sts.mark == lphs_pkg::MARK_USED,
                   "erase of a bucket not in use")

endmodule

// ===== rtl/lphs_ctrl.sv =====
`include "linear_probe_hash_set_macros.svh"

module lphs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lphs_pkg::FUNC_W-1:0] func,
  output logic                        busy,
  output lphs_pkg::lphs_cmd_t         cmd,
  input  lphs_pkg::lphs_sts_t         sts
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [lphs_pkg::FUNC_W-1:0] op_r;
  logic [lphs_pkg::FUNC_W-1:0] op_nxt;
  logic                        seen_r;
  logic                        seen_nxt;
  logic                        match;

  assign match = (sts.mark == lphs_pkg::MARK_USED) && sts.key_eq;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    seen_nxt  = seen_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_mark = lphs_pkg::MARK_NEVER;
        cmd.ptr_adv = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_nxt   = func;
          seen_nxt = 1'b0;
          if (func == lphs_pkg::OP_NONE) begin
            cmd.res_load = 1'b1;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          cmd.set_home = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_r == lphs_pkg::OP_INSERT) begin
          if (sts.mark != lphs_pkg::MARK_USED) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_mark  = lphs_pkg::MARK_USED;
            cmd.cnt_inc  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_hit  = 1'b1;
            state_nxt    = ST_IDLE;
          end else if (sts.next_home) begin
            cmd.res_load = 1'b1;
            cmd.res_full = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.ptr_adv = 1'b1;
            state_nxt   = ST_READ;
          end
        end else if (!sts.at_home && sts.mark == lphs_pkg::MARK_NEVER) begin
          // end of the cluster
          cmd.res_load = 1'b1;
          cmd.res_hit  = seen_r;
          state_nxt    = ST_IDLE;
        end else if (match && op_r == lphs_pkg::OP_FIND) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          if (match) begin
            // erase: leave a tombstone, keep walking
            cmd.wr_en   = 1'b1;
            cmd.wr_mark = lphs_pkg::MARK_GONE;
            cmd.cnt_dec = 1'b1;
            seen_nxt    = 1'b1;
          end
          if (sts.next_home) begin
            cmd.res_load = 1'b1;
            cmd.res_hit  = seen_r || match;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.ptr_adv = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  `LPHS_ASSERT_NXT(a_accept_leaves_idle, start && !busy && func != lphs_pkg::OP_NONE, busy, "accepted word did not start a walk")
  `LPHS_ASSERT_IMP(a_check_after_read, state_r == ST_CHECK, $past(state_r) == ST_READ, "bucket checked without a read")
  `LPHS_ASSERT_IMP(a_no_rd_wr_clash, cmd.wr_en, !cmd.rd_en, "read and write in one cycle")

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
// Open-addressing key set with linear probing and tombstones. A word is taken
// at a rising edge with start high and busy low; out_valid then marks the
// result for exactly one cycle and the receiver cannot stall it, so capture
// out_hit, out_full_res and out_occupancy on that strobe. After reset the
// block is busy while it marks every bucket never-used. An operation first
// forms the home bucket in ST_MOD (a reciprocal multiply of the key, then the
// remainder from the low bits of the quotient), then reads and checks each
// bucket probed in turn, since the single-port bucket memory has a registered
// read; the strobe comes in the cycle after the last probe and a new word may
// be taken in that same cycle. A walk probes each bucket at most once, so it
// can go around a nearly full table. Function code 3 does nothing and returns
// the current occupancy in the cycle after it is taken.
module linear_probe_hash_set #(
  parameter int BUCKETS  = 251,
  parameter int KEY_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lphs_pkg::FUNC_W-1:0] in_func,
  input  logic [KEY_BITS-1:0]         in_key,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic                        out_full_res,
  output logic [lphs_pkg::OCC_W-1:0]  out_occupancy
);

  lphs_pkg::lphs_cmd_t cmd;
  lphs_pkg::lphs_sts_t sts;

  lphs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  lphs_dp #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_key        (in_key),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_full_res  (out_full_res),
    .out_occupancy (out_occupancy)
  );

endmodule
